### src/mmip_pkg.sv
// Shared types and constants for the in-place 4x4 fixed-point matrix multiplier.
// No dependencies; imported by the interfaces, the MAC unit, the top level and the checker.
`default_nettype none

package mmip_pkg;

    localparam int ELEM_W  = 32;
    localparam int COORD_W = 2;
    localparam int CFG_W   = 3;
    localparam int ACC_W   = 64;

    localparam logic [CFG_W-1:0] DIM_RESET = 3'd4;

    localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [1:0] {
        CMD_WR_LEFT  = 2'd0,
        CMD_WR_RIGHT = 2'd1,
        CMD_IDENTITY = 2'd2,
        CMD_MULTIPLY = 2'd3
    } t_cmd;

    typedef enum logic [0:0] {
        CFG_COLUMNS = 1'b0,
        CFG_ROWS    = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_IDENT,
        S_MAC,
        S_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

`default_nettype wire

### src/mmip_req_if.sv
// Request channel of the matrix multiplier: command, element position and value.
// Depends on mmip_pkg.
`default_nettype none

interface mmip_req_if import mmip_pkg::*; ();
    logic               valid;
    logic               ready;
    t_cmd               command;
    logic [COORD_W-1:0] column_index;
    logic [COORD_W-1:0] row_index;
    logic [ELEM_W-1:0]  element_value;

    modport source (output valid, command, column_index, row_index, element_value,
                    input ready);
    modport sink   (input valid, command, column_index, row_index, element_value,
                    output ready);
endinterface

`default_nettype wire

### src/mmip_rsp_if.sv
// Result channel of the matrix multiplier: one transfer per emitted element.
// Depends on mmip_pkg.
`default_nettype none

interface mmip_rsp_if import mmip_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] result_column;
    logic [COORD_W-1:0] result_row;
    logic [ELEM_W-1:0]  result_value;
    logic               last_element;

    modport source (output valid, result_column, result_row, result_value, last_element,
                    input ready);
    modport sink   (input valid, result_column, result_row, result_value, last_element,
                    output ready);
endinterface

`default_nettype wire

### src/matrix_multiply_in_place_top.sv
// In-place fixed-point matrix multiplier, top level: element stores, sequencer, result register.
// Depends on mmip_pkg, mmip_req_if, mmip_rsp_if and mmip_mac.
//
// Requests arrive on i_req (valid/ready). Element writes to the left or right store complete
// on accept; i_req.ready stays high. Identity then writes the nc*nr left elements, one store
// write per cycle. Multiply walks the result column-major; each element issues nr operand
// fetches to the single shared MAC, then read, product, accumulate and emit follow, and the
// next element starts only after the emit; throughput is set by the one multiplier and the
// single read port of each store. i_req.ready is low until the last element is loaded.
// Results leave through a one-entry output register on o_rsp; if the receiver stalls the
// sequencer holds at the next element until the register frees, and a request can be
// accepted while the final result still waits there.
// The first element of each column captures the old left column in a small buffer, so the
// new value can be written back at once. The user writes the dimension registers through
// i_cfg_* only while idle; the block leaves this unchecked. 0 acts as 1 and values above
// MAX_DIM act as MAX_DIM. Reset (synchronous, active low) clears the control state, sets both
// dimensions to 4 and clears per-entry valid bits, so every element reads as zero until written.
`default_nettype none

module matrix_multiply_in_place_top import mmip_pkg::*; #(
    parameter int MAX_DIM   = 4,
    parameter int FRAC_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire t_cfg_reg         i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    mmip_req_if.sink              i_req,
    mmip_rsp_if.source            o_rsp
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);

    localparam logic [ELEM_W-1:0] ONE = ELEM_W'(1) << FRAC_BITS;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_cols_cfg, r_rows_cfg;
    logic [DIM_W-1:0]   r_nc, n_nc, r_nr, n_nr;
    logic [DIM_W-1:0]   nc_cl, nr_cl;
    logic [IDX_W-1:0]   r_c, n_c, r_r, n_r, r_k, n_k;

    logic [ELEM_W-1:0]  r_lmem [DEPTH];
    logic [ELEM_W-1:0]  r_rmem [DEPTH];
    logic [DEPTH-1:0]   r_lvld, r_rvld;
    logic [ELEM_W-1:0]  r_colbuf [MAX_DIM];

    logic [ELEM_W-1:0]  r_lq, r_rq, r_bufq;
    logic               r_lq_v, r_rq_v;
    t_mac_ctl           r_s1;
    logic [IDX_W-1:0]   r_s1_k;
    logic               r_s1_buf;

    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_col, r_out_row;
    logic [ELEM_W-1:0]  r_out_val;
    logic               r_out_last;

    logic               lw_en, rw_en, issue, out_load;
    logic [ADDR_W-1:0]  lw_addr, w_addr, cr_addr, la_addr, ra_addr;
    logic [ELEM_W-1:0]  lw_data;
    logic               w_in_range;
    logic               k_last, r_last, c_last;
    logic [ELEM_W-1:0]  s1_a, s1_b;
    logic               mac_done;
    logic [ELEM_W-1:0]  mac_result;

    // dimension clamp
    always_comb begin
        if (r_cols_cfg == '0) begin
            nc_cl = DIM_W'(1);
        end else if (32'(r_cols_cfg) > MAX_DIM) begin
            nc_cl = DIM_W'(MAX_DIM);
        end else begin
            nc_cl = DIM_W'(r_cols_cfg);
        end
        if (r_rows_cfg == '0) begin
            nr_cl = DIM_W'(1);
        end else if (32'(r_rows_cfg) > MAX_DIM) begin
            nr_cl = DIM_W'(MAX_DIM);
        end else begin
            nr_cl = DIM_W'(r_rows_cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= DIM_RESET;
            r_rows_cfg <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COLUMNS: r_cols_cfg <= i_cfg_data;
                CFG_ROWS:    r_rows_cfg <= i_cfg_data;
                default:     r_cols_cfg <= r_cols_cfg;
            endcase
        end
    end

    assign w_in_range = (32'(i_req.column_index) < MAX_DIM) && (32'(i_req.row_index) < MAX_DIM);
    assign w_addr  = ADDR_W'(32'(i_req.column_index) * MAX_DIM + 32'(i_req.row_index));
    assign cr_addr = ADDR_W'(32'(r_c) * MAX_DIM + 32'(r_r));
    assign la_addr = ADDR_W'(32'(r_c) * MAX_DIM + 32'(r_k));
    assign ra_addr = ADDR_W'(32'(r_k) * MAX_DIM + 32'(r_r));

    assign k_last = (DIM_W'(r_k) + DIM_W'(1)) == r_nr;
    assign r_last = (DIM_W'(r_r) + DIM_W'(1)) == r_nr;
    assign c_last = (DIM_W'(r_c) + DIM_W'(1)) == r_nc;

    assign i_req.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c  <= n_c;
        r_r  <= n_r;
        r_k  <= n_k;
        r_nc <= n_nc;
        r_nr <= n_nr;
    end

    always_comb begin
        n_state  = r_state;
        n_c      = r_c;
        n_r      = r_r;
        n_k      = r_k;
        n_nc     = r_nc;
        n_nr     = r_nr;
        lw_en    = 1'b0;
        lw_addr  = cr_addr;
        lw_data  = '0;
        rw_en    = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_c  = '0;
                    n_r  = '0;
                    n_k  = '0;
                    n_nc = nc_cl;
                    n_nr = nr_cl;
                    unique case (i_req.command)
                        CMD_WR_LEFT: begin
                            lw_en   = w_in_range;
                            lw_addr = w_addr;
                            lw_data = i_req.element_value;
                        end
                        CMD_WR_RIGHT: rw_en   = w_in_range;
                        CMD_IDENTITY: n_state = S_IDENT;
                        CMD_MULTIPLY: n_state = S_MAC;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_IDENT: begin
                lw_en   = 1'b1;
                lw_data = (r_c == r_r) ? ONE : '0;
                if (r_last) begin
                    n_r = '0;
                    if (c_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_c = r_c + IDX_W'(1);
                    end
                end else begin
                    n_r = r_r + IDX_W'(1);
                end
            end
            S_MAC: begin
                issue = 1'b1;
                if (k_last) begin
                    n_k     = '0;
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            S_WAIT: begin
                if (mac_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    lw_en    = 1'b1;
                    lw_data  = mac_result;
                    n_state  = S_MAC;
                    if (r_last) begin
                        n_r = '0;
                        if (c_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_c = r_c + IDX_W'(1);
                        end
                    end else begin
                        n_r = r_r + IDX_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // element stores
    always_ff @(posedge i_clk) begin
        if (lw_en) begin
            r_lmem[lw_addr] <= lw_data;
        end
        if (rw_en) begin
            r_rmem[w_addr] <= i_req.element_value;
        end
        if (issue) begin
            r_lq   <= r_lmem[la_addr];
            r_rq   <= r_rmem[ra_addr];
            r_lq_v <= r_lvld[la_addr];
            r_rq_v <= r_rvld[ra_addr];
            r_bufq <= r_colbuf[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvld <= '0;
            r_rvld <= '0;
        end else begin
            if (lw_en) begin
                r_lvld[lw_addr] <= 1'b1;
            end
            if (rw_en) begin
                r_rvld[w_addr] <= 1'b1;
            end
        end
    end

    // operand stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1.valid <= issue;
            r_s1.first <= (r_k == '0);
            r_s1.last  <= k_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_k   <= r_k;
        r_s1_buf <= (r_r != '0);
        if (r_s1.valid && !r_s1_buf) begin
            r_colbuf[r_s1_k] <= s1_a;
        end
    end

    always_comb begin
        if (r_s1_buf) begin
            s1_a = r_bufq;
        end else if (r_lq_v) begin
            s1_a = r_lq;
        end else begin
            s1_a = '0;
        end
        s1_b = r_rq_v ? r_rq : '0;
    end

    mmip_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_s1),
        .i_a      (s1_a),
        .i_b      (s1_b),
        .o_done   (mac_done),
        .o_result (mac_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_col  <= COORD_W'(r_c);
            r_out_row  <= COORD_W'(r_r);
            r_out_val  <= mac_result;
            r_out_last <= r_last && c_last;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.result_column = r_out_col;
    assign o_rsp.result_row    = r_out_row;
    assign o_rsp.result_value  = r_out_val;
    assign o_rsp.last_element  = r_out_last;

endmodule

`default_nettype wire

### src/mmip_mac.sv
// Shared multiply-accumulate unit: registered 32x32 product, floor shift, 64-bit
// accumulator and 32-bit saturation. Depends on mmip_pkg.
`default_nettype none

module mmip_mac import mmip_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_mac_ctl                 i_ctl,
    input  wire logic signed [ELEM_W-1:0] i_a,
    input  wire logic signed [ELEM_W-1:0] i_b,
    output logic                          o_done,
    output logic [ELEM_W-1:0]             o_result
);

    t_mac_ctl                 r_m1;
    logic signed [ACC_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;
    logic signed [ACC_W-1:0]  prod_sh;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [ACC_W-1:0]  n_acc;

    assign prod_sh = r_prod >>> FRAC_BITS;

    always_comb begin
        if (r_m1.first) begin
            acc_base = '0;
        end else begin
            acc_base = r_acc;
        end
        n_acc = acc_base + prod_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1   <= '0;
            r_done <= 1'b0;
        end else begin
            r_m1   <= i_ctl;
            r_done <= r_m1.valid && r_m1.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_prod <= i_a * i_b;
        end
        if (r_m1.valid) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        if (r_acc > SAT_MAX) begin
            o_result = SAT_MAX[ELEM_W-1:0];
        end else if (r_acc < SAT_MIN) begin
            o_result = SAT_MIN[ELEM_W-1:0];
        end else begin
            o_result = r_acc[ELEM_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

### src/mmip_checker.sv
// Port-level checks for the matrix multiplier, bound to the top level.
// Depends on mmip_pkg and matrix_multiply_in_place_top.
`default_nettype none

module mmip_checker import mmip_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_valid,
    input wire logic              i_req_ready,
    input wire t_cmd              i_req_command,
    input wire logic              i_rsp_valid,
    input wire logic              i_rsp_ready,
    input wire logic              i_rsp_last,
    input wire logic [ELEM_W-1:0] i_rsp_value
);

    logic req_acc;

    assign req_acc = i_req_valid && i_req_ready;

    a_long_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && (i_req_command == CMD_MULTIPLY || i_req_command == CMD_IDENTITY)
        |=> !i_req_ready)
        else $error("ready not dropped after multiply or identity request");

    a_write_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && (i_req_command == CMD_WR_LEFT || i_req_command == CMD_WR_RIGHT)
        |=> i_req_ready)
        else $error("element write did not complete in one cycle");

    a_busy_until_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_last |-> !i_req_ready)
        else $error("request accepted before multiply finished");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready
        |=> i_rsp_valid && $stable(i_rsp_value) && $stable(i_rsp_last))
        else $error("stalled result changed");

endmodule

bind matrix_multiply_in_place_top mmip_checker u_mmip_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_command (i_req.command),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_last    (o_rsp.last_element),
    .i_rsp_value   (o_rsp.result_value)
);

`default_nettype wire

### dv/matrix_multiply_in_place_top_tb.sv
// Testbench for matrix_multiply_in_place_top: drives element writes, identity and multiply
// requests plus dimension writes, predicts every emitted element and checks them in order.
// Depends on mmip_pkg, mmip_req_if, mmip_rsp_if and the matrix_multiply_in_place_top RTL.

module matrix_multiply_in_place_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmip_pkg::*;

    localparam int DIM           = 4;
    localparam int FRAC          = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 350;
    localparam int STEADY_ITEMS  = 60;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [ELEM_W-1:0]  value;
        logic               last;
    } t_elem;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    t_cfg_reg         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    mmip_req_if req_if ();
    mmip_rsp_if rsp_if ();

    matrix_multiply_in_place_top #(
        .MAX_DIM   (DIM),
        .FRAC_BITS (FRAC)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // predictor state
    logic [ELEM_W-1:0] left_mat  [DIM*DIM];
    logic [ELEM_W-1:0] right_mat [DIM*DIM];
    logic [CFG_W-1:0]  cols_reg;
    logic [CFG_W-1:0]  rows_reg;
    t_elem             expected_elems[$];

    int    mismatches;
    int    requests_sent;
    int    multiplies;
    int    elems_checked;
    int    cycles;
    int    stall_left;
    bit    steady;
    t_elem got;
    t_elem want;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int eff_dim(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > DIM) return DIM;
        return int'(v);
    endfunction

    function automatic void flag_mismatch(string what, logic [ELEM_W-1:0] exp_v,
                                          logic [ELEM_W-1:0] act_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, exp_v, act_v);
    endfunction

    function automatic logic [ELEM_W-1:0] pick_value();
        logic [ELEM_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = {{13{v[18]}}, v[18:0]};
            4: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'h0001_0000;
                    4: v = 32'hFFFF_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            5: v = {{9{v[22]}}, v[22:0]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        if ($urandom_range(0, 9) < 8) return CFG_W'($urandom_range(1, DIM));
        return CFG_W'($urandom_range(0, 7));
    endfunction

    // updates the stored matrices and queues the elements a multiply emits
    task automatic apply_command(t_cmd cmd, logic [COORD_W-1:0] ci, logic [COORD_W-1:0] ri,
                                 logic [ELEM_W-1:0] val);
        int                       nc;
        int                       nr;
        int                       c;
        int                       r;
        int                       k;
        logic [ELEM_W-1:0]        prior [DIM*DIM];
        logic signed [ACC_W-1:0]  a;
        logic signed [ACC_W-1:0]  b;
        logic signed [ACC_W-1:0]  acc;
        t_elem                    e;
        nc = eff_dim(cols_reg);
        nr = eff_dim(rows_reg);
        case (cmd)
            CMD_WR_LEFT:  left_mat[ci*DIM + ri] = val;
            CMD_WR_RIGHT: right_mat[ci*DIM + ri] = val;
            CMD_IDENTITY: begin
                for (c = 0; c < nc; c++)
                    for (r = 0; r < nr; r++)
                        left_mat[c*DIM + r] = (c == r) ? (ELEM_W'(1) << FRAC) : '0;
            end
            default: begin
                multiplies++;
                prior = left_mat;
                for (c = 0; c < nc; c++) begin
                    for (r = 0; r < nr; r++) begin
                        acc = '0;
                        for (k = 0; k < nr; k++) begin
                            a = $signed(prior[c*DIM + k]);
                            b = $signed(right_mat[k*DIM + r]);
                            acc = acc + ((a * b) >>> FRAC);
                        end
                        if (acc > SAT_MAX)
                            e.value = SAT_MAX[ELEM_W-1:0];
                        else if (acc < SAT_MIN)
                            e.value = SAT_MIN[ELEM_W-1:0];
                        else
                            e.value = acc[ELEM_W-1:0];
                        e.column = COORD_W'(c);
                        e.row    = COORD_W'(r);
                        e.last   = (c == nc - 1) && (r == nr - 1);
                        left_mat[c*DIM + r] = e.value;
                        expected_elems.push_back(e);
                    end
                end
            end
        endcase
    endtask

    task automatic send_item(t_cmd cmd, logic [COORD_W-1:0] ci, logic [COORD_W-1:0] ri,
                             logic [ELEM_W-1:0] val);
        if (!steady && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            req_if.valid         = 1'b0;
            req_if.command       = t_cmd'($urandom_range(0, 3));
            req_if.column_index  = COORD_W'($urandom);
            req_if.row_index     = COORD_W'($urandom);
            req_if.element_value = $urandom;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid         = 1'b1;
        req_if.command       = cmd;
        req_if.column_index  = ci;
        req_if.row_index     = ri;
        req_if.element_value = val;
        do @(posedge i_clk); while (!req_if.ready);
        apply_command(cmd, ci, ri, val);
        requests_sent++;
    endtask

    // idle the request side, wait for every expected element, then let identity finish
    task automatic drain();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (expected_elems.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_dims(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
        drain();
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = CFG_COLUMNS;
        cfg_data  = cols;
        @(negedge i_clk);
        cfg_index = CFG_ROWS;
        cfg_data  = rows;
        @(negedge i_clk);
        cfg_we   = 1'b0;
        cols_reg = cols;
        rows_reg = rows;
    endtask

    // load some elements, maybe reset left to identity, then multiply once or twice; or send one random request
    task automatic random_sequence();
        int span;
        int n;
        span = (eff_dim(cols_reg) > eff_dim(rows_reg)) ? eff_dim(cols_reg) : eff_dim(rows_reg);
        if ($urandom_range(0, 9) < 7) begin
            n = $urandom_range(1, 10);
            repeat (n) begin
                if ($urandom_range(0, 3) != 0)
                    send_item(t_cmd'($urandom_range(0, 1)),
                              COORD_W'($urandom_range(0, span - 1)),
                              COORD_W'($urandom_range(0, span - 1)), pick_value());
                else
                    send_item(t_cmd'($urandom_range(0, 1)), COORD_W'($urandom),
                              COORD_W'($urandom), pick_value());
            end
            if ($urandom_range(0, 3) == 0)
                send_item(CMD_IDENTITY, COORD_W'($urandom), COORD_W'($urandom), $urandom);
            send_item(CMD_MULTIPLY, COORD_W'($urandom), COORD_W'($urandom), $urandom);
            if ($urandom_range(0, 3) == 0)
                send_item(CMD_MULTIPLY, COORD_W'($urandom), COORD_W'($urandom), $urandom);
        end else begin
            send_item(t_cmd'($urandom_range(0, 3)), COORD_W'($urandom), COORD_W'($urandom),
                      pick_value());
        end
    endtask

    task automatic random_phase(int n_items);
        int start;
        start = requests_sent;
        set_dims(pick_dim(), pick_dim());
        while (requests_sent - start < n_items)
            random_sequence();
    endtask

    task automatic test_reset_contents();
        send_item(CMD_MULTIPLY, '0, '0, '0);
    endtask

    task automatic test_extreme_values();
        send_item(CMD_IDENTITY, '0, '0, '0);
        send_item(CMD_WR_RIGHT, 2'd0, 2'd0, 32'h7FFF_FFFF);
        send_item(CMD_WR_RIGHT, 2'd1, 2'd0, 32'h8000_0000);
        send_item(CMD_WR_RIGHT, 2'd0, 2'd1, 32'hFFFF_FFFF);
        send_item(CMD_WR_RIGHT, 2'd3, 2'd3, 32'h0001_0000);
        send_item(CMD_MULTIPLY, '0, '0, '0);
        // positive and negative saturation, flooring of tiny negative products
        send_item(CMD_WR_LEFT, 2'd0, 2'd0, 32'h7FFF_FFFF);
        send_item(CMD_WR_LEFT, 2'd0, 2'd1, 32'h7FFF_FFFF);
        send_item(CMD_WR_LEFT, 2'd1, 2'd0, 32'h8000_0000);
        send_item(CMD_WR_LEFT, 2'd1, 2'd1, 32'h8000_0000);
        send_item(CMD_WR_LEFT, 2'd2, 2'd0, 32'hFFFF_FFFF);
        send_item(CMD_WR_RIGHT, 2'd1, 2'd0, 32'h7FFF_FFFF);
        send_item(CMD_WR_RIGHT, 2'd3, 2'd2, 32'h8000_0000);
        send_item(CMD_MULTIPLY, '0, '0, '0);
    endtask

    task automatic test_dim_registers();
        // zero acts as one, above four acts as four
        set_dims(3'd0, 3'd7);
        send_item(CMD_IDENTITY, '0, '0, '0);
        send_item(CMD_MULTIPLY, '0, '0, '0);
        set_dims(3'd7, 3'd0);
        send_item(CMD_IDENTITY, '0, '0, '0);
        send_item(CMD_MULTIPLY, '0, '0, '0);
        set_dims(3'd1, 3'd1);
        send_item(CMD_IDENTITY, '0, '0, '0);
        send_item(CMD_MULTIPLY, '0, '0, '0);
        set_dims(3'd3, 3'd2);
        send_item(CMD_IDENTITY, '0, '0, '0);
        send_item(CMD_MULTIPLY, '0, '0, '0);
    endtask

    task automatic test_random_traffic();
        int start;
        start = requests_sent;
        while (requests_sent - start < RANDOM_ITEMS)
            random_phase($urandom_range(15, 40));
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        random_phase(STEADY_ITEMS);
    endtask

    // result channel stalls in random bursts, except in the steady phase
    initial begin
        rsp_if.ready = 1'b1;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready = 1'b0;
            end else if (!steady && $urandom_range(0, 5) == 0) begin
                stall_left   = $urandom_range(0, 6);
                rsp_if.ready = 1'b0;
            end else begin
                rsp_if.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.result_column, rsp_if.result_row, rsp_if.result_value,
                   rsp_if.last_element};
            if (expected_elems.size() == 0) begin
                flag_mismatch("result with nothing expected", '0, got.value);
            end else begin
                want = expected_elems.pop_front();
                elems_checked++;
                if (got.column !== want.column)
                    flag_mismatch("result_column", ELEM_W'(want.column), ELEM_W'(got.column));
                if (got.row !== want.row)
                    flag_mismatch("result_row", ELEM_W'(want.row), ELEM_W'(got.row));
                if (got.value !== want.value)
                    flag_mismatch("result_value", want.value, got.value);
                if (got.last !== want.last)
                    flag_mismatch("last_element", ELEM_W'(want.last), ELEM_W'(got.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d elements outstanding",
                     cycles, expected_elems.size());
            $display("matrix_multiply_in_place_top_tb: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_COLUMNS;
        cfg_data             = '0;
        req_if.valid         = 1'b0;
        req_if.command       = CMD_WR_LEFT;
        req_if.column_index  = '0;
        req_if.row_index     = '0;
        req_if.element_value = '0;
        steady               = 1'b0;
        mismatches           = 0;
        requests_sent        = 0;
        multiplies           = 0;
        elems_checked        = 0;
        cycles               = 0;
        cols_reg             = DIM_RESET;
        rows_reg             = DIM_RESET;
        for (int i = 0; i < DIM*DIM; i++) begin
            left_mat[i]  = '0;
            right_mat[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_contents();
        test_extreme_values();
        test_dim_registers();
        test_random_traffic();
        test_steady_stream();
        drain();

        $display("%0d requests sent, %0d multiplies, %0d result elements checked",
                 requests_sent, multiplies, elems_checked);
        $display("dimension settings included 0, 1, 4 and above 4; %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("matrix_multiply_in_place_top_tb: done, clean");
        end else begin
            $display("matrix_multiply_in_place_top_tb: done, errors");
        end
        $finish;
    end

endmodule

### matrix_multiply_in_place_top.f
src/mmip_pkg.sv
src/mmip_req_if.sv
src/mmip_rsp_if.sv
src/mmip_mac.sv
src/matrix_multiply_in_place_top.sv
src/mmip_checker.sv
dv/matrix_multiply_in_place_top_tb.sv
